// File: rtl/c3sf_pkg.sv
// Shared types and constants of the 3x3 stream convolution filter.
// No dependencies; compile first.
package c3sf_pkg;

  // Field widths fixed by the stream and register formats.
  localparam int PIX_W      = 8;
  localparam int COL_W      = 6;
  localparam int ROW_W      = 12;
  localparam int RES_W      = 32;
  localparam int TAP_W      = 16;
  localparam int COEFF_W    = 3 * TAP_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEFF_W;

  // Default geometry limits.
  localparam int MAX_WIDTH_DEF  = 62;
  localparam int MAX_HEIGHT_DEF = 4095;

  // Register reset values.
  localparam logic signed [RES_W-1:0] BORDER_RESET = 32'sd22;
  localparam logic [COL_W-1:0]        WIDTH_RESET  = 6'd5;
  localparam logic [ROW_W-1:0]        HEIGHT_RESET = 12'd5;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_MID    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

  // Output phases of one pixel, in emission order (bit positions).
  localparam int NUM_PH   = 5;
  localparam int PH_B0    = 0;  // whole top row, at end of row 0
  localparam int PH_LEFT  = 1;  // left border of the row above
  localparam int PH_INT   = 2;  // interior sum
  localparam int PH_RIGHT = 3;  // right border of the row above
  localparam int PH_FB    = 4;  // whole bottom row, at end of frame

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic signed [RES_W-1:0] filtered;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic                    run_last;
    logic                    frame_done;
  } result_t;

  // What one pixel asks of the output sequencer.
  typedef struct packed {
    logic [NUM_PH-1:0] ph;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } desc_t;

endpackage

// File: rtl/c3sf_stream_if.sv
// Valid/ready stream channel with a typed payload.
// No dependencies; the payload type is set where the channel is instantiated.
interface c3sf_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/conv3x3_stream_filter.sv
// 3x3 stream convolution filter: line stores, window, MAC pipeline, output sequencer.
// Depends on c3sf_pkg and c3sf_stream_if.
//
// Pixels enter in raster order on in_pix (payload c3sf_pkg::pixel_t), one per clock
// while in_pix.ready is high; results leave on out_res (payload c3sf_pkg::result_t),
// one word per clock at most. When pixel (r,c) is taken the filter emits interior
// output (r-1,c-1) as the signed weighted sum of its 3x3 neighborhood, border words of
// value border_r at the left and right edge of row r-1, all of row 0 at the end of row
// 0 and all of the last row at the end of the frame. A pixel goes through four register
// stages (memory read, nine products, three row sums, total) before the output
// sequencer turns it into words. A pixel that causes more than one word holds
// in_pix.ready low while the sequencer drives its words into the output register, one
// word a clock while out_res takes them; a row end from row 2 on, the end of row 0 and
// the end of the frame cause such runs, the latter two a whole row of words each. The
// two line stores are single-port-read memories with a registered read; their
// reset-to-zero comes from per-entry valid bits cleared by rst_n, so there is no
// clearing pass. Configuration must be written through cfg_we/cfg_index/cfg_data only
// while the filter is idle; the block itself does not enforce this. frame_width and
// frame_height are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT.
module conv3x3_stream_filter
  import c3sf_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  c3sf_stream_if.sink           in_pix,
  c3sf_stream_if.source         out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int PROD_W = PIX_W + 1 + TAP_W;  // unsigned pixel times signed tap
  localparam int RSUM_W = PROD_W + 2;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [COEFF_W-1:0]      coeff_r [3];
  logic signed [RES_W-1:0] border_r;
  logic [COL_W-1:0]        fwidth_r;
  logic [ROW_W-1:0]        fheight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r[0] <= '0;
      coeff_r[1] <= '0;
      coeff_r[2] <= '0;
      border_r   <= BORDER_RESET;
      fwidth_r   <= WIDTH_RESET;
      fheight_r  <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEFF_TOP:    coeff_r[0] <= cfg_data[COEFF_W-1:0];
        REG_COEFF_MID:    coeff_r[1] <= cfg_data[COEFF_W-1:0];
        REG_COEFF_BOTTOM: coeff_r[2] <= cfg_data[COEFF_W-1:0];
        REG_BORDER:       border_r   <= cfg_data[RES_W-1:0];
        REG_FRAME_WIDTH:  fwidth_r   <= cfg_data[COL_W-1:0];
        REG_FRAME_HEIGHT: fheight_r  <= cfg_data[ROW_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Clamp geometry to what the line stores and counters support.
  logic [COL_W-1:0] w_cl;
  logic [ROW_W-1:0] h_cl;

  always_comb begin
    priority if (fwidth_r < COL_W'(3))                w_cl = COL_W'(3);
    else if (fwidth_r > COL_W'(MAX_WIDTH))            w_cl = COL_W'(MAX_WIDTH);
    else                                              w_cl = fwidth_r;
    priority if (fheight_r < ROW_W'(3))               h_cl = ROW_W'(3);
    else if (fheight_r > ROW_W'(MAX_HEIGHT))          h_cl = ROW_W'(MAX_HEIGHT);
    else                                              h_cl = fheight_r;
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage advances together unless the last stage
  // holds a descriptor the sequencer cannot take yet.
  // ---------------------------------------------------------------------------
  logic adv;
  logic acc;
  logic gen_take;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;

  assign adv          = !s4_v_r || gen_take;
  assign in_pix.ready = adv;
  assign acc          = in_pix.valid && adv;

  // ---------------------------------------------------------------------------
  // Position counters and per-pixel schedule
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic             row_end;
  logic             frame_end;
  logic             r_ge2;
  desc_t            desc_in;

  assign row_end   = ({1'b0, col_r} + 7'd1) >= {1'b0, w_cl};
  assign frame_end = row_end && (({1'b0, row_r} + 13'd1) >= {1'b0, h_cl});
  assign r_ge2     = row_r >= ROW_W'(2);

  always_comb begin
    desc_in.ph[PH_B0]    = (row_r == '0) && row_end;
    desc_in.ph[PH_LEFT]  = r_ge2 && (col_r == '0);
    desc_in.ph[PH_INT]   = r_ge2 && (col_r >= COL_W'(2));
    desc_in.ph[PH_RIGHT] = r_ge2 && row_end;
    desc_in.ph[PH_FB]    = frame_end;
    desc_in.row          = row_r;
    desc_in.col          = col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (acc) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= frame_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores. Store a holds the previous row, store b the row before it.
  // Store a is read and rewritten with the new pixel in the accept cycle (read
  // returns the old word). Store b gets the word read from store a in the cycle after;
  // the next pixel always reads another column, so no forwarding.
  // ---------------------------------------------------------------------------
  logic [AW-1:0]        idx;
  logic [AW-1:0]        b_wa;
  logic [PIX_W-1:0]     a_mem [MAX_WIDTH];
  logic [PIX_W-1:0]     b_mem [MAX_WIDTH];
  logic [MAX_WIDTH-1:0] a_val_r, b_val_r;
  logic [PIX_W-1:0]     a_rd_r, b_rd_r;
  logic                 a_rdv_r, b_rdv_r;
  logic                 wb_pend_r;
  logic [PIX_W-1:0]     top, mid;
  desc_t                s1_desc_r;
  logic [PIX_W-1:0]     s1_pix_r;

  assign idx  = col_r[AW-1:0];
  assign b_wa = s1_desc_r.col[AW-1:0];
  assign mid  = a_rdv_r ? a_rd_r : '0;
  assign top  = b_rdv_r ? b_rd_r : '0;

  always_ff @(posedge clk) begin
    if (acc) begin
      a_mem[idx] <= in_pix.data;
      a_rd_r     <= a_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_rd_r <= b_mem[idx];
    end
    if (wb_pend_r) begin
      b_mem[b_wa] <= mid;
    end
  end

  // Entry valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_val_r   <= '0;
      b_val_r   <= '0;
      a_rdv_r   <= 1'b0;
      b_rdv_r   <= 1'b0;
      wb_pend_r <= 1'b0;
    end else begin
      if (acc) begin
        a_val_r[idx] <= 1'b1;
        a_rdv_r      <= a_val_r[idx];
        b_rdv_r      <= b_val_r[idx];
      end
      if (wb_pend_r) begin
        b_val_r[b_wa] <= 1'b1;
      end
      wb_pend_r <= acc;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: window and nine products
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]         win_r [6];
  logic [PIX_W-1:0]         newest [3];
  logic signed [PROD_W-1:0] prod_nxt [9];
  logic signed [PROD_W-1:0] prod_r [9];
  desc_t                    s2_desc_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_desc_r <= desc_in;
      s1_pix_r  <= in_pix.data;
    end
  end

  always_comb begin
    newest[0] = top;
    newest[1] = mid;
    newest[2] = s1_pix_r;
    for (int i = 0; i < 3; i++) begin
      prod_nxt[3*i]   = $signed({1'b0, win_r[2*i]})   * $signed(coeff_r[i][TAP_W-1:0]);
      prod_nxt[3*i+1] = $signed({1'b0, win_r[2*i+1]}) * $signed(coeff_r[i][2*TAP_W-1:TAP_W]);
      prod_nxt[3*i+2] = $signed({1'b0, newest[i]})    * $signed(coeff_r[i][3*TAP_W-1:2*TAP_W]);
    end
  end

  // Shift the window on every pixel, interior or not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 6; k++) win_r[k] <= '0;
    end else if (adv && s1_v_r) begin
      for (int i = 0; i < 3; i++) begin
        win_r[2*i]   <= win_r[2*i+1];
        win_r[2*i+1] <= newest[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3 and 4: row sums, then the total
  // ---------------------------------------------------------------------------
  logic signed [RSUM_W-1:0] rsum_r [3];
  logic signed [RES_W-1:0]  s4_sum_r;
  desc_t                    s3_desc_r, s4_desc_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) prod_r[k] <= prod_nxt[k];
      s2_desc_r <= s1_desc_r;
      for (int i = 0; i < 3; i++) begin
        rsum_r[i] <= RSUM_W'(prod_r[3*i]) + RSUM_W'(prod_r[3*i+1])
                   + RSUM_W'(prod_r[3*i+2]);
      end
      s3_desc_r <= s2_desc_r;
      s4_sum_r  <= RES_W'(rsum_r[0]) + RES_W'(rsum_r[1]) + RES_W'(rsum_r[2]);
      s4_desc_r <= s3_desc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= acc;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output sequencer: work through the pending phases of one pixel, lowest bit
  // first, one word a clock unless out_res stalls. Bursts step k_r across the row.
  // ---------------------------------------------------------------------------
  logic [NUM_PH-1:0]       pend_r;
  logic [NUM_PH-1:0]       cur_oh;
  logic [NUM_PH-1:0]       pend_after;
  logic [COL_W-1:0]        k_r;
  desc_t                   g_desc_r;
  logic signed [RES_W-1:0] g_sum_r;
  logic                    out_valid_r;
  result_t                 out_data_r;
  result_t                 res_nxt;
  logic                    slot_free;
  logic                    emit;
  logic                    in_burst;
  logic                    cur_done;
  logic                    emit_last;

  assign cur_oh     = pend_r & (~pend_r + NUM_PH'(1));
  assign in_burst   = cur_oh[PH_B0] || cur_oh[PH_FB];
  assign cur_done   = !in_burst || (k_r == w_cl - COL_W'(1));
  assign pend_after = cur_done ? (pend_r & ~cur_oh) : pend_r;
  assign slot_free  = !out_valid_r || out_res.ready;
  assign emit       = (pend_r != '0) && slot_free;
  assign emit_last  = emit && cur_done && (pend_after == '0);
  assign gen_take   = s4_v_r && ((pend_r == '0) || emit_last);

  always_comb begin
    res_nxt.filtered   = border_r;
    res_nxt.out_row    = g_desc_r.row - ROW_W'(1);
    res_nxt.out_col    = k_r;
    res_nxt.run_last   = emit_last;
    res_nxt.frame_done = emit_last && g_desc_r.ph[PH_FB];
    priority if (pend_r[PH_B0]) begin
      res_nxt.out_row = '0;
    end else if (pend_r[PH_LEFT]) begin
      res_nxt.out_col = '0;
    end else if (pend_r[PH_INT]) begin
      res_nxt.filtered = g_sum_r;
      res_nxt.out_col  = g_desc_r.col - COL_W'(1);
    end else if (pend_r[PH_RIGHT]) begin
      res_nxt.out_col = g_desc_r.col;
    end else begin
      res_nxt.out_row = g_desc_r.row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      k_r    <= '0;
    end else if (gen_take) begin
      pend_r <= s4_desc_r.ph;
      k_r    <= '0;
    end else if (emit) begin
      pend_r <= pend_after;
      k_r    <= cur_done ? '0 : k_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (gen_take) begin
      g_desc_r <= s4_desc_r;
      g_sum_r  <= s4_sum_r;
    end
  end

  // Output register: hold the word until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

`ifndef NO_ASSERTIONS
  // Counters stay inside the memory depth and the row range.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r < ROW_W'(MAX_HEIGHT)) && (col_r < COL_W'(MAX_WIDTH)))
    else $error("position counter out of range");

  // Delayed store b write never hits the column read in the same cycle.
  a_b_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wb_pend_r && acc) |-> (b_wa != idx))
    else $error("line store b write collides with read");

  // Burst column counter runs only inside a burst phase.
  a_k_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r != '0) |-> (pend_r[PH_B0] || pend_r[PH_FB]))
    else $error("burst counter active outside a burst");

  // End of frame is always the last word of its pixel.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.data.frame_done) |-> out_res.data.run_last)
    else $error("frame_done without run_last");
`endif

endmodule
